@@ src/spm_pkg.sv @@
// spm_pkg: shared constants and codes for the slotted page manager.
// No dependencies; imported by slotted_page_manager.
package spm_pkg;

    localparam int DEF_PAGE_BYTES      = 4096;
    localparam int DEF_HEADER_BYTES    = 12;
    localparam int DEF_MAX_TUPLE_BYTES = 1024;
    localparam int SLOT_BYTES          = 4;

    typedef enum logic [2:0] {
        FN_INSERT   = 3'd0,
        FN_UPDATE   = 3'd1,
        FN_DELETE   = 3'd2,
        FN_GET      = 3'd3,
        FN_WR_BYTE  = 3'd4,
        FN_RD_BYTE  = 3'd5,
        FN_REINIT   = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_NOT_LIVE = 3'd3,
        ST_BAD_BYTE = 3'd4
    } t_status;

endpackage

@@ src/spm_ram.sv @@
// spm_ram: simple dual-port RAM, one write and one registered read per cycle.
// No dependencies; holds the page bytes and the slot table.
module spm_ram #(
    parameter int DEPTH = 4096,
    parameter int W     = 8,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/slotted_page_manager.sv @@
// slotted_page_manager: sequencer for one slotted page, with byte and slot RAMs.
// Depends on spm_pkg and spm_ram.
//
// One request at a time; o_stall stays high from acceptance until the result
// is loaded, and the slot-table read starts at the accepting edge. Get, write
// byte and a shrinking update go from S_EXEC straight to S_DONE, and the next
// request can be taken once S_DONE has loaded the output register, which it
// holds off while a waiting result is stalled. Read byte, insert and a growing
// update without compaction add a state (S_RDWAIT for the page RAM read or
// S_ALLOC for the allocation). Delete then trims trailing dead slots, checking
// each in S_TRIM_RD and S_TRIM_CK until a live slot or an empty page is found.
// Compaction, when insert or a growing update needs it, rescans the whole slot
// table once per live tuple plus one final pass, and moves each tuple byte by
// byte through S_MV_RD and S_MV_WR. Reinitialise zeroes the page byte by byte.
// A result waits in the output register while the next request is taken.
module slotted_page_manager
    import spm_pkg::*;
#(
    parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int MAX_TUPLE_BYTES = DEF_MAX_TUPLE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [9:0]  i_slot_index,
    input  logic [11:0] i_tuple_size,
    input  logic [11:0] i_byte_index,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot_result,
    output logic [11:0] o_tuple_offset,
    output logic [11:0] o_tuple_length,
    output logic [7:0]  o_read_data,
    output logic [11:0] o_free_space,
    output logic [11:0] o_fragmented_space,
    output logic [9:0]  o_slot_count
);

    localparam int SLOT_CAP = (PAGE_BYTES - HEADER_BYTES) / SLOT_BYTES;
    localparam int PTR_W    = $clog2(PAGE_BYTES + 1);
    localparam int ADDR_W   = $clog2(PAGE_BYTES);
    localparam int LEN_W    = $clog2(MAX_TUPLE_BYTES + 1);
    localparam int SCNT_W   = $clog2(SLOT_CAP + 1);
    localparam int SIDX_W   = $clog2(SLOT_CAP);
    localparam int EXT_W    = PTR_W + 2;
    localparam int ENT_W    = PTR_W + LEN_W;
    localparam int BA_W     = ((PTR_W > 12) ? PTR_W : 12) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RDWAIT, S_TRIM_RD, S_TRIM_CK, S_CP_START, S_CP_SCAN,
        S_CP_PICK, S_MV_RD, S_MV_WR, S_ALLOC, S_CLEAR, S_DONE
    } t_state;

    t_state r_state;

    // page state
    logic [SCNT_W-1:0] r_slot_total;
    logic [PTR_W-1:0]  r_fp;
    logic [PTR_W-1:0]  r_live;

    // latched request
    logic [2:0]  r_func;
    logic [9:0]  r_slot;
    logic [11:0] r_size;
    logic [11:0] r_bidx;
    logic [7:0]  r_dbyte;
    logic        r_ins;

    // result in progress
    logic [2:0]  r_status;
    logic [9:0]  r_rslot;
    logic [11:0] r_roff;
    logic [11:0] r_rlen;
    logic [7:0]  r_rdata;

    // compaction
    logic [PTR_W-1:0]  r_ptr;
    logic [EXT_W-1:0]  r_limit;
    logic [SIDX_W-1:0] r_scan;
    logic [SIDX_W-1:0] r_best;
    logic [PTR_W-1:0]  r_best_off;
    logic [LEN_W-1:0]  r_best_len;
    logic              r_found;
    logic [ADDR_W-1:0] r_src_a;
    logic [ADDR_W-1:0] r_dst_a;
    logic [LEN_W-1:0]  r_mv_cnt;
    logic [ADDR_W-1:0] r_clr;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_o_status;
    logic [9:0]  r_o_slot;
    logic [11:0] r_o_off;
    logic [11:0] r_o_len;
    logic [7:0]  r_o_data;
    logic [11:0] r_o_free;
    logic [11:0] r_o_frag;
    logic [9:0]  r_o_cnt;

    // RAM ports
    logic              slot_we;
    logic [SIDX_W-1:0] slot_waddr;
    logic [ENT_W-1:0]  slot_wdata;
    logic [SIDX_W-1:0] slot_raddr;
    logic [ENT_W-1:0]  slot_rdata;
    logic              byte_we;
    logic [ADDR_W-1:0] byte_waddr;
    logic [7:0]        byte_wdata;
    logic [ADDR_W-1:0] byte_raddr;
    logic [7:0]        byte_rdata;

    // derived values
    logic [EXT_W-1:0]  w_end, w_free, w_used, w_frag, w_need;
    logic [PTR_W-1:0]  e_off;
    logic [LEN_W-1:0]  e_len;
    logic              in_range, is_live, bad_size, bad_byte, grows, no_room_grow;
    logic [PTR_W-1:0]  kill_live, size_p, alloc_fp;
    logic [BA_W-1:0]   byte_sum;
    logic [LEN_W-1:0]  pk_len;
    logic [PTR_W-1:0]  pk_ptr;
    logic              sc_hit;
    logic              accept_in;

    assign accept_in = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);

    assign e_off = slot_rdata[PTR_W-1:0];
    assign e_len = slot_rdata[ENT_W-1:PTR_W];

    always_comb begin
        w_end  = EXT_W'(HEADER_BYTES) + EXT_W'(r_slot_total) * EXT_W'(SLOT_BYTES);
        w_free = (EXT_W'(r_fp) > w_end) ? EXT_W'(r_fp) - w_end : '0;
        w_used = EXT_W'(PAGE_BYTES) - EXT_W'(r_fp);
        w_frag = (w_used > EXT_W'(r_live)) ? w_used - EXT_W'(r_live) : '0;
        w_need = EXT_W'(r_size) + EXT_W'(SLOT_BYTES);

        in_range = EXT_W'(r_slot) < EXT_W'(r_slot_total);
        is_live  = in_range && (e_off != '0);
        bad_size = (r_size == '0) || (r_size > 12'(MAX_TUPLE_BYTES));
        grows    = EXT_W'(r_size) > EXT_W'(e_len);
        no_room_grow = (w_free + w_frag + EXT_W'(e_len)) < EXT_W'(r_size);
        kill_live = (r_live > PTR_W'(e_len)) ? r_live - PTR_W'(e_len) : '0;

        byte_sum = BA_W'(e_off) + BA_W'(r_bidx);
        bad_byte = (BA_W'(r_bidx) >= BA_W'(e_len)) || (byte_sum >= BA_W'(PAGE_BYTES));

        size_p   = PTR_W'(r_size);
        alloc_fp = (r_fp > size_p) ? r_fp - size_p : '0;

        if ((PTR_W'(r_best_len) > r_ptr) ||
            ((EXT_W'(r_best_off) + EXT_W'(r_best_len)) > EXT_W'(PAGE_BYTES))) begin
            pk_len = '0;
        end else begin
            pk_len = r_best_len;
        end
        pk_ptr = r_ptr - PTR_W'(pk_len);

        sc_hit = (e_off != '0) && (EXT_W'(e_off) < r_limit) && (e_off > r_best_off);
    end

    // slot table port control
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = SIDX_W'(r_slot);
        slot_wdata = '0;
        case (r_state)
            S_IDLE:     slot_raddr = SIDX_W'(i_slot_index);
            S_TRIM_RD:  slot_raddr = SIDX_W'(r_slot_total - 1'b1);
            S_CP_SCAN:  slot_raddr = SIDX_W'(r_scan + 1'b1);
            default:    slot_raddr = '0;
        endcase
        case (r_state)
            S_EXEC: begin
                if (r_func == FN_UPDATE && is_live && !bad_size) begin
                    if (!grows) begin
                        slot_we    = 1'b1;
                        slot_wdata = {LEN_W'(r_size), e_off};
                    end else if (!((w_free < EXT_W'(r_size)) && no_room_grow)) begin
                        slot_we = 1'b1;
                    end
                end else if (r_func == FN_DELETE && is_live) begin
                    slot_we = 1'b1;
                end
            end
            S_CP_PICK: begin
                slot_we    = r_found;
                slot_waddr = r_best;
                slot_wdata = {pk_len, pk_ptr};
            end
            S_ALLOC: begin
                slot_we    = 1'b1;
                slot_waddr = r_ins ? SIDX_W'(r_slot_total) : SIDX_W'(r_slot);
                slot_wdata = {LEN_W'(r_size), alloc_fp};
            end
            default: ;
        endcase
    end

    // page byte port control
    always_comb begin
        byte_we    = 1'b0;
        byte_waddr = ADDR_W'(byte_sum);
        byte_wdata = r_dbyte;
        byte_raddr = ADDR_W'(byte_sum);
        case (r_state)
            S_EXEC:  byte_we = (r_func == FN_WR_BYTE) && is_live && !bad_byte;
            S_MV_RD: byte_raddr = r_src_a;
            S_MV_WR: begin
                byte_we    = 1'b1;
                byte_waddr = r_dst_a;
                byte_wdata = byte_rdata;
            end
            S_CLEAR: begin
                byte_we    = 1'b1;
                byte_waddr = r_clr;
                byte_wdata = '0;
            end
            default: ;
        endcase
    end

    spm_ram #(.DEPTH(SLOT_CAP), .W(ENT_W), .AW(SIDX_W)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    spm_ram #(.DEPTH(PAGE_BYTES), .W(8), .AW(ADDR_W)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_total <= '0;
            r_fp         <= PTR_W'(PAGE_BYTES);
            r_live       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            // S_DONE handles the output register itself
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_func   <= i_func;
                        r_slot   <= i_slot_index;
                        r_size   <= i_tuple_size;
                        r_bidx   <= i_byte_index;
                        r_dbyte  <= i_data_byte;
                        r_status <= ST_OK;
                        r_rslot  <= i_slot_index;
                        r_roff   <= '0;
                        r_rlen   <= '0;
                        r_rdata  <= '0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_ptr   <= PTR_W'(PAGE_BYTES);
                    r_limit <= EXT_W'(PAGE_BYTES + 1);
                    case (r_func)
                        FN_INSERT: begin
                            r_rslot <= '0;
                            r_ins   <= 1'b1;
                            if (bad_size) begin
                                r_status <= ST_BAD_SIZE;
                                r_state  <= S_DONE;
                            end else if (EXT_W'(r_slot_total) >= EXT_W'(SLOT_CAP)) begin
                                r_status <= ST_NO_SPACE;
                                r_state  <= S_DONE;
                            end else if (w_free < w_need) begin
                                if ((w_free + w_frag) < w_need) begin
                                    r_status <= ST_NO_SPACE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_CP_START;
                                end
                            end else begin
                                r_state <= S_ALLOC;
                            end
                        end
                        FN_UPDATE: begin
                            r_ins <= 1'b0;
                            if (!is_live) begin
                                r_status <= ST_NOT_LIVE;
                                r_state  <= S_DONE;
                            end else if (bad_size) begin
                                r_status <= ST_BAD_SIZE;
                                r_state  <= S_DONE;
                            end else if (!grows) begin
                                r_live  <= r_live - PTR_W'(e_len) + size_p;
                                r_roff  <= 12'(e_off);
                                r_rlen  <= r_size;
                                r_state <= S_DONE;
                            end else if (w_free < EXT_W'(r_size)) begin
                                if (no_room_grow) begin
                                    r_status <= ST_NO_SPACE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_live  <= kill_live;
                                    r_state <= S_CP_START;
                                end
                            end else begin
                                r_live  <= kill_live;
                                r_state <= S_ALLOC;
                            end
                        end
                        FN_DELETE: begin
                            if (!is_live) begin
                                r_status <= ST_NOT_LIVE;
                                r_state  <= S_DONE;
                            end else begin
                                r_roff  <= 12'(e_off);
                                r_rlen  <= 12'(e_len);
                                r_live  <= kill_live;
                                r_state <= S_TRIM_RD;
                            end
                        end
                        FN_GET, FN_WR_BYTE, FN_RD_BYTE: begin
                            if (!is_live) begin
                                r_status <= ST_NOT_LIVE;
                                r_state  <= S_DONE;
                            end else begin
                                r_roff <= 12'(e_off);
                                r_rlen <= 12'(e_len);
                                if (r_func != FN_GET && bad_byte) begin
                                    r_status <= ST_BAD_BYTE;
                                    r_state  <= S_DONE;
                                end else if (r_func == FN_RD_BYTE) begin
                                    r_state <= S_RDWAIT;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                        end
                        FN_REINIT: begin
                            r_slot_total <= '0;
                            r_fp         <= PTR_W'(PAGE_BYTES);
                            r_live       <= '0;
                            r_clr        <= '0;
                            r_state      <= S_CLEAR;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_RDWAIT: begin
                    r_rdata <= byte_rdata;
                    r_state <= S_DONE;
                end
                S_TRIM_RD: begin
                    r_state <= (r_slot_total == '0) ? S_DONE : S_TRIM_CK;
                end
                S_TRIM_CK: begin
                    if (e_off == '0) begin
                        r_slot_total <= r_slot_total - 1'b1;
                        r_state      <= S_TRIM_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CP_START: begin
                    r_scan     <= '0;
                    r_best_off <= '0;
                    r_found    <= 1'b0;
                    r_state    <= (r_slot_total == '0) ? S_CP_PICK : S_CP_SCAN;
                end
                S_CP_SCAN: begin
                    if (sc_hit) begin
                        r_best     <= r_scan;
                        r_best_off <= e_off;
                        r_best_len <= e_len;
                        r_found    <= 1'b1;
                    end
                    if ((EXT_W'(r_scan) + 1'b1) < EXT_W'(r_slot_total)) begin
                        r_scan <= r_scan + 1'b1;
                    end else begin
                        r_state <= S_CP_PICK;
                    end
                end
                S_CP_PICK: begin
                    if (!r_found) begin
                        r_fp    <= r_ptr;
                        r_state <= S_ALLOC;
                    end else begin
                        r_limit  <= EXT_W'(r_best_off);
                        r_ptr    <= pk_ptr;
                        r_src_a  <= ADDR_W'(r_best_off + PTR_W'(pk_len) - 1'b1);
                        r_dst_a  <= ADDR_W'(pk_ptr + PTR_W'(pk_len) - 1'b1);
                        r_mv_cnt <= pk_len;
                        r_state  <= (pk_len == '0) ? S_CP_START : S_MV_RD;
                    end
                end
                S_MV_RD: begin
                    r_state <= S_MV_WR;
                end
                S_MV_WR: begin
                    // copy runs from the top byte down since the tuple only moves up
                    if (r_mv_cnt == LEN_W'(1)) begin
                        r_state <= S_CP_START;
                    end else begin
                        r_mv_cnt <= r_mv_cnt - 1'b1;
                        r_src_a  <= r_src_a - 1'b1;
                        r_dst_a  <= r_dst_a - 1'b1;
                        r_state  <= S_MV_RD;
                    end
                end
                S_ALLOC: begin
                    r_fp   <= alloc_fp;
                    r_live <= r_live + size_p;
                    r_roff <= 12'(alloc_fp);
                    r_rlen <= r_size;
                    if (r_ins) begin
                        r_rslot      <= 10'(r_slot_total);
                        r_slot_total <= r_slot_total + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_CLEAR: begin
                    if (r_clr == ADDR_W'(PAGE_BYTES - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_slot   <= r_rslot;
                        r_o_off    <= r_roff;
                        r_o_len    <= r_rlen;
                        r_o_data   <= r_rdata;
                        r_o_free   <= 12'(w_free);
                        r_o_frag   <= 12'(w_frag);
                        r_o_cnt    <= 10'(r_slot_total);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_status           = r_o_status;
    assign o_slot_result      = r_o_slot;
    assign o_tuple_offset     = r_o_off;
    assign o_tuple_length     = r_o_len;
    assign o_read_data        = r_o_data;
    assign o_free_space       = r_o_free;
    assign o_fragmented_space = r_o_frag;
    assign o_slot_count       = r_o_cnt;

endmodule
